### sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro takes a label, a clock, a reset, the condition pair and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sccb_pkg.sv
package sccb_pkg;

  // Bus sequencer phase codes
  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_ST1  = 5'd1;
  localparam logic [4:0] PH_ST2  = 5'd2;
  localparam logic [4:0] PH_BLO  = 5'd3;
  localparam logic [4:0] PH_BHI  = 5'd4;
  localparam logic [4:0] PH_ALO  = 5'd5;
  localparam logic [4:0] PH_AHI  = 5'd6;
  localparam logic [4:0] PH_ATL  = 5'd7;
  localparam logic [4:0] PH_SP1  = 5'd8;
  localparam logic [4:0] PH_SP2  = 5'd9;
  localparam logic [4:0] PH_SP3  = 5'd10;
  localparam logic [4:0] PH_RLO  = 5'd11;
  localparam logic [4:0] PH_RHI  = 5'd12;
  localparam logic [4:0] PH_NA1  = 5'd13;
  localparam logic [4:0] PH_NA2  = 5'd14;
  localparam logic [4:0] PH_NA3  = 5'd15;

  // Byte positions within a transaction
  localparam logic [1:0] STAGE_DEV  = 2'd0;
  localparam logic [1:0] STAGE_REG  = 2'd1;
  localparam logic [1:0] STAGE_DATA = 2'd2;

  // Acknowledge error codes of a write
  localparam logic [1:0] ACK_OK       = 2'd0;
  localparam logic [1:0] ACK_DEVICE   = 2'd1;
  localparam logic [1:0] ACK_REGISTER = 2'd2;
  localparam logic [1:0] ACK_DATA     = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_DELAY_UNITS    = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;
  localparam logic [1:0] REG_STRICT_ACK     = 2'd3;

  // Register reset values
  localparam logic [7:0] RST_DEVICE_ADDRESS = 8'd96;
  localparam logic [9:0] RST_DELAY_UNITS    = 10'd1;
  localparam logic [7:0] RST_ACK_TIMEOUT    = 8'd250;

  localparam logic [15:0] SEG_LEN_MAX = 16'hFFFF;

  // Read sets bit 0 of the device address
  localparam logic [7:0] READ_BIT = 8'h01;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] seg_last;      // segment length minus one
    logic [7:0]  ack_timeout;
    logic        strict_ack;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic       cmd_valid;
    logic       func;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // One result item
  typedef struct packed {
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       status;
    logic [1:0] ack_error;
    logic [7:0] read_data;
    logic [7:0] last_reg_addr;
  } res_t;

endpackage

### sv/sccb_cfg.sv
module sccb_cfg
  import sccb_pkg::*;
#(
  parameter int DELAY_SCALE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  localparam logic [15:0] RESET_LAST = 16'(DELAY_SCALE - 1);

  logic [7:0]  device_address;
  logic [9:0]  delay_units;
  logic [7:0]  ack_timeout;
  logic        strict_ack;
  logic [15:0] seg_last;
  logic [15:0] seg_last_next;
  logic [31:0] prod;
  logic        wr_en;
  logic [1:0]  index;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign index  = paddr[3:2];

  // Scale the written delay into a saturated segment length
  always_comb begin
    prod = 32'(pwdata[9:0]) * 32'(DELAY_SCALE);
    if (prod > 32'(SEG_LEN_MAX)) begin
      seg_last_next = SEG_LEN_MAX - 16'd1;
    end else if (prod == 32'd0) begin
      seg_last_next = 16'd0;
    end else begin
      seg_last_next = prod[15:0] - 16'd1;
    end
  end

  // Register file writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= RST_DEVICE_ADDRESS;
      delay_units    <= RST_DELAY_UNITS;
      ack_timeout    <= RST_ACK_TIMEOUT;
      strict_ack     <= 1'b0;
      seg_last       <= RESET_LAST;
    end else if (wr_en) begin
      unique case (index)
        REG_DEVICE_ADDRESS: device_address <= pwdata[7:0];
        REG_DELAY_UNITS: begin
          delay_units <= pwdata[9:0];
          seg_last    <= seg_last_next;
        end
        REG_ACK_TIMEOUT: ack_timeout <= pwdata[7:0];
        REG_STRICT_ACK:  strict_ack  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (index)
      REG_DEVICE_ADDRESS: prdata = {24'd0, device_address};
      REG_DELAY_UNITS:    prdata = {22'd0, delay_units};
      REG_ACK_TIMEOUT:    prdata = {24'd0, ack_timeout};
      REG_STRICT_ACK:     prdata = {31'd0, strict_ack};
      default:            prdata = 32'd0;
    endcase
  end

  assign cfg = '{device_address: device_address, seg_last: seg_last,
                 ack_timeout: ack_timeout, strict_ack: strict_ack};

endmodule

### sv/sccb_seq.sv
`include "assert_macros.svh"

module sccb_seq
  import sccb_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [4:0]  phase, phase_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] delay_count, delay_count_next;
  logic [7:0]  retry_count, retry_count_next;
  logic        is_read, is_read_next;
  logic [7:0]  held_reg, held_reg_next;
  logic [7:0]  held_value, held_value_next;
  logic [1:0]  error_code, error_code_next;
  logic [7:0]  received, received_next;
  logic [1:0]  stage, stage_next;
  logic [7:0]  last_write_reg, last_write_reg_next;
  logic        scl, rel, busy, done;

  // One tick of the bus sequencer
  always_comb begin
    phase_next          = phase;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    delay_count_next    = delay_count;
    retry_count_next    = retry_count;
    is_read_next        = is_read;
    held_reg_next       = held_reg;
    held_value_next     = held_value;
    error_code_next     = error_code;
    received_next       = received;
    stage_next          = stage;
    last_write_reg_next = last_write_reg;
    scl  = 1'b1;
    rel  = 1'b1;
    done = 1'b0;

    // Start a transaction from idle
    if (phase == PH_IDLE && item.cmd_valid) begin
      is_read_next     = item.func;
      held_reg_next    = item.reg_addr;
      held_value_next  = item.write_data;
      stage_next       = STAGE_DEV;
      delay_count_next = 16'd0;
      if (!item.func) begin
        error_code_next     = ACK_OK;
        last_write_reg_next = item.reg_addr;
      end
      phase_next = PH_ST1;
    end

    busy = (phase_next != PH_IDLE);

    if (busy) begin
      // Pin levels of the current segment
      unique case (phase_next)
        PH_ST1: begin scl = 1'b1; rel = 1'b1; end
        PH_ST2: begin scl = 1'b1; rel = 1'b0; end
        PH_BLO: begin scl = 1'b0; rel = shift_byte_next[7]; end
        PH_BHI: begin scl = 1'b1; rel = shift_byte_next[7]; end
        PH_SP1: begin scl = 1'b0; rel = 1'b0; end
        PH_SP2: begin scl = 1'b1; rel = 1'b0; end
        PH_AHI, PH_SP3, PH_RHI, PH_NA2: begin scl = 1'b1; rel = 1'b1; end
        default: begin scl = 1'b0; rel = 1'b1; end
      endcase

      // Advance the segment timer, move on at its end
      if (delay_count_next >= cfg.seg_last) begin
        delay_count_next = 16'd0;
        unique case (phase_next)
          PH_ST1: phase_next = PH_ST2;
          PH_ST2: begin
            shift_byte_next = (is_read_next && stage_next == STAGE_DATA) ?
                              (cfg.device_address | READ_BIT) : cfg.device_address;
            bit_count_next  = 3'd0;
            phase_next      = PH_BLO;
          end
          PH_BLO: phase_next = PH_BHI;
          PH_BHI: begin
            shift_byte_next = {shift_byte_next[6:0], 1'b0};
            bit_count_next  = bit_count_next + 3'd1;
            if (bit_count_next == 3'd0) begin
              retry_count_next = 8'd0;
              phase_next       = PH_ALO;
            end else begin
              phase_next = PH_BLO;
            end
          end
          PH_ALO: phase_next = PH_AHI;
          PH_AHI: begin
            if (!item.sda_in || retry_count_next >= cfg.ack_timeout) begin
              if (item.sda_in && !is_read_next) begin
                error_code_next = stage_next + 2'd1;
              end
              phase_next = PH_ATL;
            end else begin
              retry_count_next = retry_count_next + 8'd1;
            end
          end
          PH_ATL: begin
            if (!is_read_next) begin
              if (error_code_next != ACK_OK || stage_next >= STAGE_DATA) begin
                phase_next = PH_SP1;
              end else begin
                stage_next      = stage_next + 2'd1;
                shift_byte_next = (stage_next == STAGE_REG) ? held_reg_next
                                                            : held_value_next;
                bit_count_next  = 3'd0;
                phase_next      = PH_BLO;
              end
            end else if (stage_next == STAGE_DEV) begin
              stage_next      = STAGE_REG;
              shift_byte_next = held_reg_next;
              bit_count_next  = 3'd0;
              phase_next      = PH_BLO;
            end else if (stage_next == STAGE_REG) begin
              phase_next = PH_SP1;
            end else begin
              shift_byte_next = 8'd0;
              bit_count_next  = 3'd0;
              phase_next      = PH_RLO;
            end
          end
          PH_SP1: phase_next = PH_SP2;
          PH_SP2: phase_next = PH_SP3;
          PH_SP3: begin
            if (is_read_next && stage_next == STAGE_REG) begin
              stage_next = STAGE_DATA;
              phase_next = PH_ST1;
            end else begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end
          end
          PH_RLO: phase_next = PH_RHI;
          PH_RHI: begin
            shift_byte_next = {shift_byte_next[6:0], item.sda_in};
            bit_count_next  = bit_count_next + 3'd1;
            if (bit_count_next == 3'd0) begin
              received_next = shift_byte_next;
              phase_next    = PH_NA1;
            end else begin
              phase_next = PH_RLO;
            end
          end
          PH_NA1: phase_next = PH_NA2;
          PH_NA2: phase_next = PH_NA3;
          PH_NA3: phase_next = PH_SP1;
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        delay_count_next = delay_count_next + 16'd1;
      end
    end
  end

  // Result of this tick
  assign res = '{scl: scl, sda_release: rel, busy_res: busy, done_res: done,
                 status: cfg.strict_ack & (error_code_next != ACK_OK),
                 ack_error: error_code_next, read_data: received_next,
                 last_reg_addr: last_write_reg_next};

  // Sequencer state, updated once per accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      bit_count      <= 3'd0;
      shift_byte     <= 8'd0;
      delay_count    <= 16'd0;
      retry_count    <= 8'd0;
      is_read        <= 1'b0;
      held_reg       <= 8'd0;
      held_value     <= 8'd0;
      error_code     <= ACK_OK;
      received       <= 8'd0;
      stage          <= STAGE_DEV;
      last_write_reg <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      delay_count    <= delay_count_next;
      retry_count    <= retry_count_next;
      is_read        <= is_read_next;
      held_reg       <= held_reg_next;
      held_value     <= held_value_next;
      error_code     <= error_code_next;
      received       <= received_next;
      stage          <= stage_next;
      last_write_reg <= last_write_reg_next;
    end
  end

  `ASSERT_SAME(a_done_busy, clk, rst, res.done_res, res.busy_res, "done without busy")
  `ASSERT_SAME(a_idle_quiet, clk, rst, phase == PH_IDLE && !item.cmd_valid,
               !res.busy_res && res.scl && res.sda_release, "idle tick not quiet")
  `ASSERT_NEXT(a_done_idle, clk, rst, step && res.done_res, phase == PH_IDLE,
               "finished transaction left sequencer busy")

endmodule

### sv/sccb_register_master_top.sv
// Channel  | Port group                  | Payload
// ---------+-----------------------------+----------------------------------------
// in       | s_tvalid/s_tready/s_tdata   | one bus tick: command, sda sample
// out      | m_tvalid/m_tready/m_tdata   | pin levels and status for that tick
// config   | psel/penable/pwrite/paddr   | four registers at byte addresses 0..12
//
// One tick per cycle sustained while m_tready is held high; an accepted tick's result is
// presented after it passes the input register, then the result register.
// The sequencer advances only when the input register holds a tick and the
// result register is empty or being drained, so m_tready stalls ripple back.
// rst is synchronous, active high, and resets all registers but the in_item and out_res data.

`include "assert_macros.svh"

module sccb_register_master_top
  import sccb_pkg::*;
#(
  parameter int DELAY_SCALE = 64
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // cmd_valid[0], reg_addr[8:1], write_data[16:9], sda_in[17]
  input  logic        s_tuser,  // func
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // scl[0], sda_release[1], busy_res[2], status[3],
                                // ack_error[5:4], read_data[13:6], last_reg_addr[21:14]
  output logic        m_tlast,  // done_res
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg;
  item_t in_item;
  logic  in_valid;
  logic  advance;
  logic  s_fire;
  res_t  res;
  res_t  out_res;

  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;
  assign s_fire   = s_tvalid & s_tready;

  sccb_cfg #(
    .DELAY_SCALE(DELAY_SCALE)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_item <= '{cmd_valid: s_tdata[0], func: s_tuser, reg_addr: s_tdata[8:1],
                   write_data: s_tdata[16:9], sda_in: s_tdata[17]};
    end
  end

  sccb_seq u_seq (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .item(in_item),
    .cfg (cfg),
    .res (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.last_reg_addr, out_res.read_data, out_res.ack_error,
                    out_res.status, out_res.busy_res, out_res.sda_release, out_res.scl};
  assign m_tlast = out_res.done_res;

  `ASSERT_NEXT(a_advance_fills, clk, rst, advance, m_tvalid, "advanced tick produced no result")
  `ASSERT_NEXT(a_accept_holds, clk, rst, s_fire, in_valid, "accepted tick not held")
  `ASSERT_NEXT(a_hold_stable, clk, rst, in_valid && !advance && !s_fire,
               in_valid && $stable(in_item), "held tick lost while stalled")

endmodule
